// ===== design/uart_rx_fifo_with_error_tags_macros.svh =====
// ----------------------------------------------------------------------------
// UART receive FIFO assertion macros
// Assertion forms for the receive FIFO controller.
// ----------------------------------------------------------------------------
`ifndef UART_RX_FIFO_WITH_ERROR_TAGS_MACROS_SVH
`define UART_RX_FIFO_WITH_ERROR_TAGS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RXF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RXF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rxf_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO package
// Types, codes and constants shared by the receive FIFO modules.
// ----------------------------------------------------------------------------
package rxf_pkg;

    localparam int FIFO_DEPTH_DEF = 64;
    localparam int MAX_RUN        = 64;
    localparam int RUN_W          = $clog2(MAX_RUN + 1);
    localparam int FILL_W         = 7;
    localparam int DATA_W         = 8;
    localparam int TAG_W          = 4;
    localparam int REQ_W          = 2;
    localparam int LEN_W          = 7;
    localparam int WORD_W         = DATA_W + TAG_W;

    // Request codes carried on the request type field.
    typedef enum logic [REQ_W-1:0] {
        REQ_RECEIVE = 2'd0,
        REQ_READ    = 2'd1,
        REQ_DISCARD = 2'd2
    } t_req;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT,
        ST_DRAIN
    } t_state;

    // Memory port strobes.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ===== design/rxf_mem.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO storage
// Simple dual-port memory holding a tag and a data byte per entry, with a
// registered read port.
// ----------------------------------------------------------------------------
module rxf_mem
    import rxf_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rxf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO controller
// Pointers, counts and the read-run sequencer. A read run first scans the
// entries it will pop to settle the final error count and head tag, then
// streams the popped bytes out one per cycle.
// ----------------------------------------------------------------------------
`include "uart_rx_fifo_with_error_tags_macros.svh"

module rxf_ctrl
    import rxf_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [DATA_W-1:0] i_line_byte,
    input  logic              i_parity_error,
    input  logic              i_framing_error,
    input  logic              i_noise_error,
    input  logic              i_line_overrun,
    input  logic [LEN_W-1:0]  i_read_len,
    output logic              o_result_stb,
    output logic [DATA_W-1:0] o_read_data,
    output logic [TAG_W-1:0]  o_read_flags,
    output logic              o_read_valid,
    output logic              o_last_of_run,
    output logic [FILL_W-1:0] o_fill_level,
    output logic              o_has_error,
    output logic [TAG_W-1:0]  o_next_flags,
    output logic              o_byte_dropped,
    output t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [WORD_W-1:0] o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [WORD_W-1:0] i_mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > RUN_W) ? CW : RUN_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_RUN);

    // Wrap-around pointer increment.
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // Control state.
    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_tagged, n_tagged;
    logic              r_pend, n_pend;
    logic              r_scan_vld, n_scan_vld;
    logic              r_emit_vld, n_emit_vld;
    logic              r_o_stb, n_o_stb;

    // Run bookkeeping and result payload.
    logic [TAG_W-1:0]  r_head_tag, n_head_tag;
    logic [RUN_W-1:0]  r_n, n_n;
    logic [RUN_W-1:0]  r_issue, n_issue;
    logic [RUN_W-1:0]  r_nz, n_nz;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]     r_new_head, n_new_head;
    logic              r_clr, n_clr;
    logic              r_emit_last, n_emit_last;
    logic [DATA_W-1:0] r_o_data, n_o_data;
    logic [TAG_W-1:0]  r_o_flags, n_o_flags;
    logic              r_o_valid, n_o_valid;
    logic              r_o_last, n_o_last;
    logic [FILL_W-1:0] r_o_fill, n_o_fill;
    logic              r_o_err, n_o_err;
    logic [TAG_W-1:0]  r_o_next, n_o_next;
    logic              r_o_dropped, n_o_dropped;

    // Helpers.
    logic              rx_pend;
    logic [TAG_W-1:0]  rx_tag;
    logic [RUN_W-1:0]  len_eff;
    logic [MW-1:0]     len_m, cnt_m, run_m, tag_m, nz_m;
    logic [RUN_W-1:0]  run_n;
    logic              run_clr;
    logic [TAG_W-1:0]  rd_tag;
    logic [DATA_W-1:0] rd_data;
    logic [31:0]       cnt_ext;

    assign rd_tag  = i_mem_rdata[WORD_W-1:DATA_W];
    assign rd_data = i_mem_rdata[DATA_W-1:0];

    // Tag of an incoming byte, with any pending overrun folded in.
    assign rx_pend = r_pend | i_line_overrun;
    assign rx_tag  = {i_noise_error, i_framing_error, i_parity_error, rx_pend};

    // Length of a read run: clipped to the longest run, then to the fill.
    assign len_eff = (i_read_len > LEN_W'(MAX_RUN)) ? RUN_MAX : RUN_W'(i_read_len);
    assign len_m   = MW'(len_eff);
    assign cnt_m   = MW'(r_count);
    assign run_m   = (len_m < cnt_m) ? len_m : cnt_m;
    assign run_n   = RUN_W'(run_m);
    assign run_clr = (len_m > cnt_m);

    // Saturating error count after the scan.
    assign tag_m = MW'(r_tagged);
    assign nz_m  = MW'(r_nz);

    // Next state and outputs of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_tagged    = r_tagged;
        n_pend      = r_pend;
        n_scan_vld  = 1'b0;
        n_emit_vld  = 1'b0;
        n_emit_last = 1'b0;
        n_head_tag  = r_head_tag;
        n_n         = r_n;
        n_issue     = r_issue;
        n_nz        = r_nz;
        n_rd_ptr    = r_rd_ptr;
        n_new_head  = r_new_head;
        n_clr       = r_clr;
        n_o_stb     = 1'b0;
        n_o_data    = r_o_data;
        n_o_flags   = r_o_flags;
        n_o_valid   = r_o_valid;
        n_o_last    = r_o_last;
        n_o_dropped = r_o_dropped;

        o_mem_ctl   = '0;
        o_mem_waddr = r_tail;
        o_mem_wdata = {rx_tag, i_line_byte};
        o_mem_raddr = r_rd_ptr;

        // Count tagged entries as scan data returns.
        if (r_scan_vld && (rd_tag != '0)) begin
            n_nz = r_nz + 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_o_stb     = 1'b1;
                    n_o_data    = '0;
                    n_o_flags   = '0;
                    n_o_valid   = 1'b0;
                    n_o_last    = 1'b1;
                    n_o_dropped = 1'b0;
                    case (t_req'(i_req_type))
                        REQ_RECEIVE: begin
                            if (r_count == CNT_FULL) begin
                                n_pend      = 1'b1;
                                n_o_dropped = 1'b1;
                            end else begin
                                n_pend          = 1'b0;
                                o_mem_ctl.wr_en = 1'b1;
                                n_tail          = ptr_inc(r_tail);
                                n_count         = r_count + 1'b1;
                                if (rx_tag != '0) begin
                                    n_tagged = r_tagged + 1'b1;
                                end
                                if (r_count == '0) begin
                                    n_head_tag = rx_tag;
                                end
                            end
                        end
                        REQ_READ: begin
                            if (run_n == '0) begin
                                if (run_clr) begin
                                    n_tagged = '0;
                                end
                            end else begin
                                n_o_stb  = 1'b0;
                                n_n      = run_n;
                                n_issue  = '0;
                                n_nz     = '0;
                                n_clr    = run_clr;
                                n_rd_ptr = r_head;
                                n_state  = ST_SCAN;
                            end
                        end
                        REQ_DISCARD: begin
                            n_head   = '0;
                            n_tail   = '0;
                            n_count  = '0;
                            n_tagged = '0;
                            n_pend   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Read every entry of the run, then the entry that becomes the head.
            ST_SCAN: begin
                o_mem_ctl.rd_en = 1'b1;
                n_rd_ptr        = ptr_inc(r_rd_ptr);
                n_issue         = r_issue + 1'b1;
                if (r_issue == r_n) begin
                    n_new_head = r_rd_ptr;
                    n_state    = ST_SCAN_END;
                end else begin
                    n_scan_vld = 1'b1;
                end
            end
            // Commit the state left behind by the run.
            ST_SCAN_END: begin
                n_head_tag = rd_tag;
                n_head     = r_new_head;
                n_count    = r_count - CW'(r_n);
                if (r_clr || (nz_m >= tag_m)) begin
                    n_tagged = '0;
                end else begin
                    n_tagged = CW'(tag_m - nz_m);
                end
                n_rd_ptr = r_head;
                n_issue  = '0;
                n_state  = ST_EMIT;
            end
            // Read the popped bytes again, one per cycle, for delivery.
            ST_EMIT: begin
                o_mem_ctl.rd_en = 1'b1;
                n_rd_ptr        = ptr_inc(r_rd_ptr);
                n_issue         = r_issue + 1'b1;
                n_emit_vld      = 1'b1;
                if (r_issue == (r_n - 1'b1)) begin
                    n_emit_last = 1'b1;
                    n_state     = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A popped byte arrives from the memory.
        if (r_emit_vld) begin
            n_o_stb     = 1'b1;
            n_o_data    = rd_data;
            n_o_flags   = rd_tag;
            n_o_valid   = 1'b1;
            n_o_last    = r_emit_last;
            n_o_dropped = 1'b0;
        end
    end

    // Status fields reflect the state after the item.
    assign cnt_ext  = 32'(n_count);
    assign n_o_fill = cnt_ext[FILL_W-1:0];
    assign n_o_err  = (n_tagged != '0);
    assign n_o_next = (n_count != '0) ? n_head_tag : '0;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_tagged   <= '0;
            r_pend     <= 1'b0;
            r_scan_vld <= 1'b0;
            r_emit_vld <= 1'b0;
            r_o_stb    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_tagged   <= n_tagged;
            r_pend     <= n_pend;
            r_scan_vld <= n_scan_vld;
            r_emit_vld <= n_emit_vld;
            r_o_stb    <= n_o_stb;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_head_tag  <= n_head_tag;
        r_n         <= n_n;
        r_issue     <= n_issue;
        r_nz        <= n_nz;
        r_rd_ptr    <= n_rd_ptr;
        r_new_head  <= n_new_head;
        r_clr       <= n_clr;
        r_emit_last <= n_emit_last;
        r_o_data    <= n_o_data;
        r_o_flags   <= n_o_flags;
        r_o_valid   <= n_o_valid;
        r_o_last    <= n_o_last;
        r_o_fill    <= n_o_fill;
        r_o_err     <= n_o_err;
        r_o_next    <= n_o_next;
        r_o_dropped <= n_o_dropped;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_stb   = r_o_stb;
    assign o_read_data    = r_o_data;
    assign o_read_flags   = r_o_flags;
    assign o_read_valid   = r_o_valid;
    assign o_last_of_run  = r_o_last;
    assign o_fill_level   = r_o_fill;
    assign o_has_error    = r_o_err;
    assign o_next_flags   = r_o_next;
    assign o_byte_dropped = r_o_dropped;

    // The fill never passes the depth.
    `RXF_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL, "fill above depth")
    // Tagged entries are a subset of the stored entries.
    `RXF_ASSERT_NOW(a_tagged_bound, i_clk, i_rst_n, 1'b1, r_tagged <= r_count, "tag count above fill")
    // No result is delivered while the run is being scanned.
    `RXF_ASSERT_NOW(a_scan_quiet, i_clk, i_rst_n, (r_state == ST_SCAN) || (r_state == ST_SCAN_END), !r_o_stb, "result during scan")
    // A dropped byte is reported only with a full FIFO.
    `RXF_ASSERT_NOW(a_drop_full, i_clk, i_rst_n, r_o_stb && r_o_dropped, r_count == CNT_FULL, "drop while not full")
    // The last byte of a run is followed by a return to idle.
    `RXF_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, r_emit_vld && r_emit_last, r_state == ST_IDLE, "run did not end")

endmodule

// ===== design/uart_rx_fifo_with_error_tags.sv =====
// ----------------------------------------------------------------------------
// UART receive FIFO with error tags
// Top level: controller and tag/data storage.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Receive, discard
// and unused commands, and reads that pop nothing, leave busy low: the
// result appears on the next cycle and a new command may follow right away.
// A read run that pops bytes keeps busy high while the single memory read
// port is walked twice, once to settle the error count and the new head tag
// and once to stream the bytes; the popped bytes then come out one per cycle.
// Every result is shown for exactly one cycle under o_result_stb and must
// be taken then, since the receiver has no way to hold results back. The
// storage has no reset and needs no clearing pass after reset.
module uart_rx_fifo_with_error_tags
    import rxf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [DATA_W-1:0] i_line_byte,
    input  logic              i_parity_error,
    input  logic              i_framing_error,
    input  logic              i_noise_error,
    input  logic              i_line_overrun,
    input  logic [LEN_W-1:0]  i_read_len,
    output logic              o_result_stb,
    output logic [DATA_W-1:0] o_read_data,
    output logic [TAG_W-1:0]  o_read_flags,
    output logic              o_read_valid,
    output logic              o_last_of_run,
    output logic [FILL_W-1:0] o_fill_level,
    output logic              o_has_error,
    output logic [TAG_W-1:0]  o_next_flags,
    output logic              o_byte_dropped
);

    localparam int AW = $clog2(FIFO_DEPTH);

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    // Pointers, counts and run sequencing.
    rxf_ctrl #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_req_type      (i_req_type),
        .i_line_byte     (i_line_byte),
        .i_parity_error  (i_parity_error),
        .i_framing_error (i_framing_error),
        .i_noise_error   (i_noise_error),
        .i_line_overrun  (i_line_overrun),
        .i_read_len      (i_read_len),
        .o_result_stb    (o_result_stb),
        .o_read_data     (o_read_data),
        .o_read_flags    (o_read_flags),
        .o_read_valid    (o_read_valid),
        .o_last_of_run   (o_last_of_run),
        .o_fill_level    (o_fill_level),
        .o_has_error     (o_has_error),
        .o_next_flags    (o_next_flags),
        .o_byte_dropped  (o_byte_dropped),
        .o_mem_ctl       (mem_ctl),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    // Tag and data storage.
    rxf_mem #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receive FIFO with error tags: testbench
// Commands are planned up front (a short directed list, then random traffic
// with bursts that fill the FIFO past full), sent one transfer at a time
// with random gaps, and mirrored by a FIFO model that predicts every result.
// A monitor compares each strobed result field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench
    import rxf_pkg::*;
();

    // Tag bit positions, also used to carry the error inputs of a command.
    localparam logic [TAG_W-1:0] TAG_OVERRUN = 4'b0001;
    localparam logic [TAG_W-1:0] TAG_PARITY  = 4'b0010;
    localparam logic [TAG_W-1:0] TAG_FRAMING = 4'b0100;
    localparam logic [TAG_W-1:0] TAG_NOISE   = 4'b1000;
    localparam logic [TAG_W-1:0] TAG_NONE    = 4'b0000;

    // Request code that the block does not define.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 260;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 12;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] line_byte;
        logic [TAG_W-1:0]  errs;
        logic [LEN_W-1:0]  len;
        int                gap;
        bit                hold;
    } t_rx_cmd;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [TAG_W-1:0]  flags;
        logic              valid;
        logic              last;
        logic [FILL_W-1:0] fill;
        logic              has_err;
        logic [TAG_W-1:0]  next_flags;
        logic              dropped;
    } t_rx_result;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              start           = 1'b0;
    logic              busy;
    logic [REQ_W-1:0]  i_req_type      = '0;
    logic [DATA_W-1:0] i_line_byte     = '0;
    logic              i_parity_error  = 1'b0;
    logic              i_framing_error = 1'b0;
    logic              i_noise_error   = 1'b0;
    logic              i_line_overrun  = 1'b0;
    logic [LEN_W-1:0]  i_read_len      = '0;
    logic              o_result_stb;
    logic [DATA_W-1:0] o_read_data;
    logic [TAG_W-1:0]  o_read_flags;
    logic              o_read_valid;
    logic              o_last_of_run;
    logic [FILL_W-1:0] o_fill_level;
    logic              o_has_error;
    logic [TAG_W-1:0]  o_next_flags;
    logic              o_byte_dropped;

    t_rx_cmd    cmd_plan_q[$];
    t_rx_result result_due_q[$];
    int         planned        = 0;
    int         sent_count     = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // Mirror of the FIFO contents and its bookkeeping.
    logic [DATA_W-1:0] mirror_data [FIFO_DEPTH_DEF];
    logic [TAG_W-1:0]  mirror_tag  [FIFO_DEPTH_DEF];
    logic [5:0]        mirror_head    = '0;
    logic [5:0]        mirror_tail    = '0;
    int                mirror_count   = 0;
    int                mirror_tagged  = 0;
    bit                mirror_ovr_pnd = 1'b0;

    uart_rx_fifo_with_error_tags uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_line_byte     (i_line_byte),
        .i_parity_error  (i_parity_error),
        .i_framing_error (i_framing_error),
        .i_noise_error   (i_noise_error),
        .i_line_overrun  (i_line_overrun),
        .i_read_len      (i_read_len),
        .o_result_stb    (o_result_stb),
        .o_read_data     (o_read_data),
        .o_read_flags    (o_read_flags),
        .o_read_valid    (o_read_valid),
        .o_last_of_run   (o_last_of_run),
        .o_fill_level    (o_fill_level),
        .o_has_error     (o_has_error),
        .o_next_flags    (o_next_flags),
        .o_byte_dropped  (o_byte_dropped)
    );

    always #1 i_clk = ~i_clk;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Status fields reflect the mirror after the whole command.
    function automatic t_rx_result fifo_status_result();
        t_rx_result r;
        r.data       = '0;
        r.flags      = '0;
        r.valid      = 1'b0;
        r.last       = 1'b0;
        r.fill       = FILL_W'(mirror_count);
        r.has_err    = (mirror_tagged != 0);
        r.next_flags = (mirror_count != 0) ? mirror_tag[mirror_head] : TAG_NONE;
        r.dropped    = 1'b0;
        return r;
    endfunction

    // Apply one accepted command to the mirror and queue the results it causes.
    task automatic fifo_mirror_step(input t_rx_cmd cmd);
        t_rx_result        r;
        logic [DATA_W-1:0] got_data[$];
        logic [TAG_W-1:0]  got_tag[$];
        logic [TAG_W-1:0]  tag;
        int                run_len;
        bit                dropped;
        dropped = 1'b0;
        case (cmd.req)
            REQ_RECEIVE: begin
                if ((cmd.errs & TAG_OVERRUN) != 0) mirror_ovr_pnd = 1'b1;
                if (mirror_count >= FIFO_DEPTH_DEF) begin
                    // Full: the byte is lost and the next stored byte gets the overrun.
                    mirror_ovr_pnd = 1'b1;
                    dropped        = 1'b1;
                end else begin
                    tag = (cmd.errs & ~TAG_OVERRUN) | (mirror_ovr_pnd ? TAG_OVERRUN : TAG_NONE);
                    mirror_ovr_pnd = 1'b0;
                    if (tag != TAG_NONE) mirror_tagged++;
                    mirror_data[mirror_tail] = cmd.line_byte;
                    mirror_tag[mirror_tail]  = tag;
                    mirror_tail++;
                    mirror_count++;
                end
            end
            REQ_READ: begin
                run_len = (cmd.len > MAX_RUN) ? MAX_RUN : int'(cmd.len);
                for (int i = 0; i < run_len; i++) begin
                    if (mirror_count == 0) begin
                        // Popping an empty FIFO clears the error count.
                        mirror_tagged = 0;
                        break;
                    end
                    got_data.push_back(mirror_data[mirror_head]);
                    got_tag.push_back(mirror_tag[mirror_head]);
                    if (mirror_tag[mirror_head] != TAG_NONE && mirror_tagged > 0) begin
                        mirror_tagged--;
                    end
                    mirror_head++;
                    mirror_count--;
                end
            end
            REQ_DISCARD: begin
                mirror_head    = '0;
                mirror_tail    = '0;
                mirror_count   = 0;
                mirror_tagged  = 0;
                mirror_ovr_pnd = 1'b0;
            end
            default: begin
            end
        endcase

        if (got_data.size() == 0) begin
            r         = fifo_status_result();
            r.last    = 1'b1;
            r.dropped = dropped;
            result_due_q.push_back(r);
        end else begin
            foreach (got_data[k]) begin
                r       = fifo_status_result();
                r.data  = got_data[k];
                r.flags = got_tag[k];
                r.valid = 1'b1;
                r.last  = (k == got_data.size() - 1);
                result_due_q.push_back(r);
            end
        end
    endtask

    task automatic plan(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] line_byte,
                        input logic [TAG_W-1:0] errs, input logic [LEN_W-1:0] len,
                        input int gap, input bit hold);
        t_rx_cmd cmd;
        cmd.req       = req;
        cmd.line_byte = line_byte;
        cmd.errs      = errs;
        cmd.len       = len;
        cmd.gap       = gap;
        cmd.hold      = hold;
        cmd_plan_q.push_back(cmd);
        planned++;
    endtask

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Line errors are the exception: parity, framing and noise each a quarter of the time, overrun an eighth.
    function automatic logic [TAG_W-1:0] pick_errs();
        logic [TAG_W-1:0] errs;
        errs = TAG_NONE;
        if ($urandom_range(0, 7) == 0) errs |= TAG_OVERRUN;
        if ($urandom_range(0, 3) == 0) errs |= TAG_PARITY;
        if ($urandom_range(0, 3) == 0) errs |= TAG_FRAMING;
        if ($urandom_range(0, 3) == 0) errs |= TAG_NOISE;
        return errs;
    endfunction

    // Short runs dominate; some are long, clipped, or zero length.
    function automatic logic [LEN_W-1:0] pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return LEN_W'($urandom_range(1, 8));
        if (roll < 90) return LEN_W'($urandom_range(9, 63));
        if (roll < 97) return LEN_W'($urandom_range(64, 127));
        return '0;
    endfunction

    // Drive the next planned command once its gap has run out and, for a held command, once no result is pending.
    always @(posedge i_clk) begin : drive_proc
        logic           accepted;
        static t_rx_cmd nxt;
        static bit      have_nxt = 1'b0;
        static int      gap_left = 0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                fifo_mirror_step(nxt);
                have_nxt = 1'b0;
                sent_count++;
            end
            if (accepted || !start) begin
                if (!have_nxt && cmd_plan_q.size() != 0) begin
                    nxt      = cmd_plan_q.pop_front();
                    have_nxt = 1'b1;
                    gap_left = nxt.gap;
                end
                if (have_nxt && gap_left == 0 && !(nxt.hold && result_due_q.size() != 0)) begin
                    start           <= 1'b1;
                    i_req_type      <= nxt.req;
                    i_line_byte     <= nxt.line_byte;
                    i_line_overrun  <= nxt.errs[0];
                    i_parity_error  <= nxt.errs[1];
                    i_framing_error <= nxt.errs[2];
                    i_noise_error   <= nxt.errs[3];
                    i_read_len      <= nxt.len;
                end else begin
                    start <= 1'b0;
                    if (have_nxt && gap_left > 0) gap_left--;
                end
            end
        end
    end

    // Compare each strobed result with the oldest prediction.
    always @(posedge i_clk) begin : watch_proc
        t_rx_result want;
        if (i_rst_n && o_result_stb) begin
            if (result_due_q.size() == 0) begin
                report_mismatch("result strobe with no result pending");
            end else begin
                want = result_due_q.pop_front();
                check_field("read_data", o_read_data, want.data);
                check_field("read_flags", o_read_flags, want.flags);
                check_field("read_valid", o_read_valid, want.valid);
                check_field("last_of_run", o_last_of_run, want.last);
                check_field("fill_level", o_fill_level, want.fill);
                check_field("has_error", o_has_error, want.has_err);
                check_field("next_flags", o_next_flags, want.next_flags);
                check_field("byte_dropped", o_byte_dropped, want.dropped);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stim_proc
        int burst;
        int step;
        int roll;
        int directed_end;

        // Directed: read on empty, each tag bit alone and all together,
        // zero, clipped and empty runs, the unused code and a discard.
        plan(REQ_READ,    8'h00, TAG_NONE, 7'd1, 0, 1'b0);
        plan(REQ_RECEIVE, 8'h00, TAG_NONE, 7'd0, 0, 1'b0);
        plan(REQ_RECEIVE, 8'hFF, TAG_OVERRUN | TAG_PARITY | TAG_FRAMING | TAG_NOISE,
             7'd127, 0, 1'b0);
        plan(REQ_RECEIVE, 8'hA5, TAG_PARITY, 7'd0, 1, 1'b0);
        plan(REQ_RECEIVE, 8'h5A, TAG_FRAMING, 7'd0, 0, 1'b0);
        plan(REQ_RECEIVE, 8'h3C, TAG_NOISE, 7'd0, 0, 1'b0);
        plan(REQ_RECEIVE, 8'hC3, TAG_OVERRUN, 7'd0, 2, 1'b0);
        plan(REQ_READ,    8'h00, TAG_NONE, 7'd0, 0, 1'b0);
        plan(REQ_READ,    8'hFF, TAG_NONE, 7'd2, 0, 1'b0);
        plan(REQ_UNUSED,  8'h96, TAG_NONE, 7'd5, 0, 1'b0);
        plan(REQ_READ,    8'h00, TAG_NONE, 7'd127, 0, 1'b0);
        plan(REQ_READ,    8'h00, TAG_NONE, 7'd64, 3, 1'b0);
        plan(REQ_RECEIVE, 8'h81, TAG_PARITY | TAG_NOISE, 7'd0, 0, 1'b0);
        plan(REQ_RECEIVE, 8'h7E, TAG_NONE, 7'd0, 0, 1'b0);
        plan(REQ_RECEIVE, 8'h42, TAG_OVERRUN, 7'd0, 0, 1'b0);
        plan(REQ_DISCARD, 8'h00, TAG_NONE, 7'd3, 0, 1'b0);
        plan(REQ_READ,    8'h00, TAG_NONE, 7'd1, 0, 1'b0);
        plan(REQ_RECEIVE, 8'h18, TAG_FRAMING, 7'd0, 0, 1'b0);
        plan(REQ_READ,    8'h00, TAG_NONE, 7'd64, 0, 1'b0);
        directed_end = planned;

        // Random traffic, with two bursts that run the FIFO past full.
        step = 0;
        while (planned < directed_end + RANDOM_ITEMS) begin
            if (step == 30 || step == 120) begin
                burst = FIFO_DEPTH_DEF + $urandom_range(2, 6);
                for (int i = 0; i < burst; i++) begin
                    plan(REQ_RECEIVE, DATA_W'($urandom_range(0, 255)), pick_errs(),
                         LEN_W'($urandom_range(0, 127)),
                         (i % 20 < 12) ? 0 : pick_gap(), 1'b0);
                end
                plan(REQ_READ, 8'h00, TAG_NONE, LEN_W'($urandom_range(1, 10)), pick_gap(),
                     1'b0);
                plan(REQ_RECEIVE, DATA_W'($urandom_range(0, 255)), pick_errs(), 7'd0,
                     pick_gap(), 1'b0);
                plan(REQ_READ, 8'h00, TAG_NONE, LEN_W'($urandom_range(64, 127)),
                     pick_gap(), 1'b1);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    plan(REQ_RECEIVE, DATA_W'($urandom_range(0, 255)), pick_errs(),
                         LEN_W'($urandom_range(0, 127)), pick_gap(),
                         step == 0 || $urandom_range(0, 24) == 0);
                end else if (roll < 85) begin
                    plan(REQ_READ, DATA_W'($urandom_range(0, 255)), pick_errs(), pick_len(),
                         pick_gap(), $urandom_range(0, 24) == 0);
                end else if (roll < 93) begin
                    plan(REQ_DISCARD, DATA_W'($urandom_range(0, 255)), pick_errs(),
                         pick_len(), pick_gap(), 1'b0);
                end else begin
                    plan(REQ_UNUSED, DATA_W'($urandom_range(0, 255)), pick_errs(),
                         pick_len(), pick_gap(), 1'b0);
                end
            end
            step++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let every command go out and every result come back.
        while (sent_count < planned) @(posedge i_clk);
        while (result_due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
